FILE: rtl/wwmf_pkg.sv
// Package for the weighted window max filter: word types, window sizing,
// the Q1.16 tap weight function and the reduction tree sizing helpers.
// No dependencies.
`default_nettype none

package wwmf_pkg;

   localparam int HALF_WINDOW = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int WORD_BITS   = 16;
   localparam int WEIGHT_BITS = 17;
   localparam int FRAC_BITS   = 16;
   localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
   localparam int CENTER      = HALF_WINDOW;
   localparam int FLUSH_BITS  = $clog2(HALF_WINDOW + 1);
   localparam int ONE_Q16     = 65536;

   localparam logic [WORD_BITS-1:0] SAMPLE_MASK =
      (SAMPLE_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}}
                                 : WORD_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

   typedef struct packed {
      logic [WORD_BITS-1:0] sample;
      logic                 frame_end;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] smoothed;
      logic                 end_of_frame;
   } rsp_type;

   // round(65536 * ((H-d)/H)^(1/4)), exact halves up. Binary search on
   // (2w-1)^4 * H <= 2^68 * (H-d); elaboration time only.
   function automatic logic [WEIGHT_BITS-1:0] weight_of(int unsigned d);
      logic [17:0] lo;
      logic [17:0] hi;
      logic [17:0] mid;
      logic [17:0] odd;
      logic [79:0] lhs;
      logic [79:0] rhs;
      lo = '0;
      hi = 18'(ONE_Q16);
      for (int i = 0; i < 20; i++) begin
         if (lo < hi) begin
            mid = (lo + hi + 18'd1) >> 1;
            odd = (mid << 1) - 18'd1;
            lhs = 80'(odd) * 80'(odd) * 80'(odd) * 80'(odd) * 80'(HALF_WINDOW);
            rhs = (80'(HALF_WINDOW) - 80'(d)) << 68;
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 18'd1;
            end
         end
      end
      return lo[WEIGHT_BITS-1:0];
   endfunction

   // entries at a level of the 4-way max tree; level 0 is the tap row
   function automatic int tree_width(int level);
      int n;
      n = WIN_LEN;
      for (int i = 0; i < level; i++) begin
         n = (n + 3) / 4;
      end
      return n;
   endfunction

   function automatic int tree_depth();
      int n;
      int l;
      n = WIN_LEN;
      l = 0;
      while (n > 1) begin
         n = (n + 3) / 4;
         l++;
      end
      return l;
   endfunction

   localparam int TREE_LEVELS = tree_depth();

endpackage

`default_nettype wire

FILE: rtl/weighted_window_max_filter.sv
// Weighted sliding window max filter, top level.
// Depends on wwmf_pkg (word structs, sizing, tap weights).
`default_nettype none

//  channel | dir | handshake            | word
//  --------+-----+----------------------+-----------------------------------
//  req     | in  | req_valid/req_ready  | req_type: sample, frame_end
//  rsp     | out | rsp_valid/rsp_ready  | rsp_type: smoothed, end_of_frame
//
// One word in per cycle while the window is free and no flush runs. A
// frame_end word starts a flush of HALF_WINDOW empty slots, in which
// req_ready is low, that push out the trailing positions. A result is
// registered in the window, the product row and each tree level.
// Synchronous active-high reset clears the window marks, flush state and
// pipeline valids. A stalled rsp backs up stage by stage; bubbles inside
// the pipe are squeezed out before req_ready drops.

module weighted_window_max_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wwmf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wwmf_pkg::rsp_type rsp_data
);
   import wwmf_pkg::*;

   // window shift line, newest word at the top index
   logic [WORD_BITS-1:0]  win_data_ff [WIN_LEN];
   logic [WORD_BITS-1:0]  win_data_in [WIN_LEN];
   logic [WIN_LEN-1:0]    win_vld_ff;
   logic [WIN_LEN-1:0]    win_vld_in;
   // window holds a center position whose result is still to be computed
   logic                  cand_ff;
   logic                  cand_in;
   logic                  cand_eof_ff;
   logic                  cand_eof_in;
   // frame ended: next shift drops every old entry
   logic                  wipe_ff;
   logic                  wipe_in;
   logic [FLUSH_BITS-1:0] flush_cnt_ff;
   logic [FLUSH_BITS-1:0] flush_cnt_in;

   logic                  flushing;
   logic                  win_free;
   logic                  take_word;
   logic                  flush_shift;
   logic                  do_shift;

   // product row and max tree; level 0 is the product row
   logic [WORD_BITS-1:0]  prod_in [WIN_LEN];
   logic [WORD_BITS-1:0]  tree_ff [TREE_LEVELS+1][WIN_LEN];
   logic [TREE_LEVELS:0]  stg_vld_ff;
   logic [TREE_LEVELS:0]  stg_eof_ff;
   logic [TREE_LEVELS:0]  stg_load;

   // ---------------------------------------------------------------
   // Window control. Every accepted word or flush slot shifts the line
   // down by one; the center tap is then the position to report.
   // ---------------------------------------------------------------
   always_comb begin
      flushing    = (flush_cnt_ff != '0);
      win_free    = !cand_ff || stg_load[0];
      req_ready   = win_free && !flushing;
      take_word   = req_valid && req_ready;
      flush_shift = flushing && win_free;
      do_shift    = take_word || flush_shift;

      win_data_in  = win_data_ff;
      win_vld_in   = win_vld_ff;
      cand_eof_in  = cand_eof_ff;
      wipe_in      = wipe_ff;
      flush_cnt_in = flush_cnt_ff;
      cand_in      = cand_ff && !stg_load[0];

      if (do_shift) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_data_in[i] = win_data_ff[i+1];
            win_vld_in[i]  = win_vld_ff[i+1] && !wipe_ff;
         end
         win_data_in[WIN_LEN-1] = req_data.sample & SAMPLE_MASK;
         win_vld_in[WIN_LEN-1]  = take_word;
         cand_in     = win_vld_in[CENTER];
         // the last flush slot reports the frame's final position
         cand_eof_in = flush_shift && (flush_cnt_ff == FLUSH_BITS'(1));
         wipe_in     = flush_shift && (flush_cnt_ff == FLUSH_BITS'(1));
         if (take_word) begin
            flush_cnt_in = req_data.frame_end ? FLUSH_BITS'(HALF_WINDOW) : '0;
         end else begin
            flush_cnt_in = flush_cnt_ff - FLUSH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_vld_ff   <= '0;
         cand_ff      <= 1'b0;
         wipe_ff      <= 1'b0;
         flush_cnt_ff <= '0;
      end else begin
         win_vld_ff   <= win_vld_in;
         cand_ff      <= cand_in;
         wipe_ff      <= wipe_in;
         flush_cnt_ff <= flush_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win_data_ff <= win_data_in;
      cand_eof_ff <= cand_eof_in;
   end

   // ---------------------------------------------------------------
   // Taps: each has a fixed distance from the center, so its weight is
   // a constant. Invalid taps feed zero, which never wins the max.
   // ---------------------------------------------------------------
   for (genvar k = 0; k < WIN_LEN; k++) begin : g_tap
      localparam int unsigned TAP_DIST = (k < CENTER) ? (CENTER - k) : (k - CENTER);
      localparam logic [WEIGHT_BITS-1:0] TAP_WEIGHT = weight_of(TAP_DIST);
      logic [WORD_BITS-1:0]             tap_val;
      logic [WORD_BITS+WEIGHT_BITS-1:0] tap_full;
      always_comb begin
         tap_val  = win_vld_ff[k] ? win_data_ff[k] : '0;
         tap_full = (WORD_BITS+WEIGHT_BITS)'(tap_val)
                    * (WORD_BITS+WEIGHT_BITS)'(TAP_WEIGHT);
      end
      // weight <= 1.0, so the shifted product fits the word
      assign prod_in[k] = tap_full[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
   end

   // ---------------------------------------------------------------
   // Pipeline flow: a stage loads when empty or when its word moves on.
   // ---------------------------------------------------------------
   always_comb begin
      stg_load[TREE_LEVELS] = !stg_vld_ff[TREE_LEVELS] || rsp_ready;
      for (int i = TREE_LEVELS - 1; i >= 0; i--) begin
         stg_load[i] = !stg_vld_ff[i] || stg_load[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
      end else begin
         if (stg_load[0]) begin
            stg_vld_ff[0] <= cand_ff;
         end
         for (int i = 1; i <= TREE_LEVELS; i++) begin
            if (stg_load[i]) begin
               stg_vld_ff[i] <= stg_vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_load[0]) begin
         stg_eof_ff[0] <= cand_eof_ff;
         tree_ff[0]    <= prod_in;
      end
      for (int i = 1; i <= TREE_LEVELS; i++) begin
         if (stg_load[i]) begin
            stg_eof_ff[i] <= stg_eof_ff[i-1];
         end
      end
   end

   // registered 4-way max tree
   for (genvar l = 1; l <= TREE_LEVELS; l++) begin : g_level
      localparam int PREV = tree_width(l - 1);
      localparam int CUR  = tree_width(l);
      logic [WORD_BITS-1:0] grp_max [CUR];
      always_comb begin
         for (int e = 0; e < CUR; e++) begin
            grp_max[e] = '0;
            for (int c = 0; c < 4; c++) begin
               if ((4 * e + c) < PREV) begin
                  if (tree_ff[l-1][(4*e+c < PREV) ? (4*e+c) : (PREV-1)] > grp_max[e]) begin
                     grp_max[e] = tree_ff[l-1][(4*e+c < PREV) ? (4*e+c) : (PREV-1)];
                  end
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (stg_load[l]) begin
            for (int e = 0; e < CUR; e++) begin
               tree_ff[l][e] <= grp_max[e];
            end
         end
      end
   end

   assign rsp_valid             = stg_vld_ff[TREE_LEVELS];
   assign rsp_data.smoothed     = tree_ff[TREE_LEVELS][0];
   assign rsp_data.end_of_frame = stg_eof_ff[TREE_LEVELS];

endmodule

`default_nettype wire

FILE: verif/weighted_window_max_filter_tb.sv
// Self-checking testbench for weighted_window_max_filter: random and directed
// frames of samples against a cycle-free predictor of the weighted window max.
// Depends on wwmf_pkg (req_type, rsp_type, window sizing) and the RTL top level.
`default_nettype none

module weighted_window_max_filter_tb;
   import wwmf_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS = 270;
   localparam int TAIL_ITEMS   = 40;    // last words of the run go out with no idling
   localparam int HOLD_AFTER   = 40;    // results seen before the long receiver hold
   localparam int HOLD_CYCLES  = 300;   // long hold, long enough to back up the window
   localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 24;    // pipe is TREE_LEVELS+2 deep, plus margin

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   weighted_window_max_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: own copy of the tap weights, the sample line and
   // its valid marks. Index WIN_LEN-1 holds the newest sample.
   // ------------------------------------------------------------------
   logic [WEIGHT_BITS-1:0] tap_weight [0:HALF_WINDOW];
   logic [WORD_BITS-1:0]   sample_line [0:WIN_LEN-1];
   logic                   line_valid [0:WIN_LEN-1];

   req_type pending_words [$];    // stimulus not yet offered
   rsp_type expected_smoothed [$]; // results predicted, not yet seen

   int  error_count = 0;
   int  rsp_count   = 0;
   int  gap_left    = 0;
   int  stall_left  = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;
   bit  tail_phase  = 1'b0;
   int  idle_cycles = 0;
   rsp_type seen_word;
   rsp_type want_word;

   // Exact test for the Q1.16 weight: w - 1/2 <= 65536 * ((H-d)/H)^(1/4)
   // is the same as (2w-1)^4 * H <= 2^68 * (H-d).
   function automatic bit weight_within(int unsigned w, int unsigned d);
      logic [95:0] odd;
      logic [95:0] lhs;
      logic [95:0] rhs;
      if (w == 0) begin
         return 1'b1;
      end
      odd = 96'(2 * w - 1);
      lhs = odd * odd * odd * odd * 96'(HALF_WINDOW);
      rhs = 96'(HALF_WINDOW - d) << 68;
      return lhs <= rhs;
   endfunction

   // Start from the floating point estimate, then walk to the exact
   // rounded value so the table does not depend on real precision.
   task automatic build_tap_weights();
      real         r;
      int unsigned w;
      for (int d = 0; d <= HALF_WINDOW; d++) begin
         r = 65536.0 * ((real'(HALF_WINDOW - d) / real'(HALF_WINDOW)) ** 0.25);
         w = $rtoi(r + 0.5);
         if (w > ONE_Q16) begin
            w = ONE_Q16;
         end
         while (w > 0 && !weight_within(w, d)) begin
            w--;
         end
         while (w < ONE_Q16 && weight_within(w + 1, d)) begin
            w++;
         end
         tap_weight[d] = WEIGHT_BITS'(w);
      end
   endtask

   // One accepted word: shift it in, then emit the center position, or
   // on frame_end the center and every position after it (flush).
   task automatic predict_smoothed(req_type word);
      int              last;
      int              c;
      int              k;
      int              tap_dist;
      logic [32:0]     prod;
      logic [32:0]     best;
      rsp_type         result;
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         sample_line[i] = sample_line[i + 1];
         line_valid[i]  = line_valid[i + 1];
      end
      sample_line[WIN_LEN - 1] = word.sample & SAMPLE_MASK;
      line_valid[WIN_LEN - 1]  = 1'b1;
      last = word.frame_end ? HALF_WINDOW : 0;
      for (int s = 0; s <= last; s++) begin
         c = CENTER + s;
         if (line_valid[c]) begin
            best = '0;
            for (int j = -HALF_WINDOW; j <= HALF_WINDOW; j++) begin
               k        = c + j;
               tap_dist = (j < 0) ? -j : j;
               // neighbors past either end of the frame are skipped
               if (k >= 0 && k < WIN_LEN && line_valid[k]) begin
                  prod = (33'(sample_line[k]) * 33'(tap_weight[tap_dist])) >> FRAC_BITS;
                  if (prod > best) begin
                     best = prod;
                  end
               end
            end
            result.smoothed     = best[WORD_BITS-1:0];
            result.end_of_frame = word.frame_end && (s == last);
            expected_smoothed.insert(expected_smoothed.size(), result);
         end
      end
      if (word.frame_end) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            sample_line[i] = '0;
            line_valid[i]  = 1'b0;
         end
      end
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at result %0d: %s got %0h expected %0h", rsp_count, what, got, want);
      error_count++;
   endtask

   task automatic queue_word(logic [WORD_BITS-1:0] sample, logic frame_end);
      req_type word;
      word.sample    = sample;
      word.frame_end = frame_end;
      pending_words.insert(pending_words.size(), word);
   endtask

   // Mix of extremes, small, near-full and full random values so that both
   // the weighting of large samples and near-ties between taps show up.
   function automatic logic [WORD_BITS-1:0] pick_sample();
      unique case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return WORD_BITS'($urandom_range(0, 255));
         end
         3: begin
            return WORD_BITS'(16'hFF00 | $urandom_range(0, 255));
         end
         default: begin
            return WORD_BITS'($urandom);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers words from pending_words. Prediction happens on the
   // accepting edge; results only come out later from the registered pipe,
   // so the monitor never races the push.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_smoothed(req_data);
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0 && !tail_phase &&
                         $urandom_range(0, 5) == 0) begin
               // idle burst, gap_left drawn from 0 to 4
               gap_left  <= $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         tail_phase <= (pending_words.size() <= TAIL_ITEMS);
      end
   end

   // ------------------------------------------------------------------
   // Receiver: short random stalls, plus one long hold once enough
   // results have passed, while the driver keeps offering words.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word = rsp_data;
         if (expected_smoothed.size() == 0) begin
            report_mismatch("unexpected word", 32'(seen_word), 32'd0);
         end else begin
            want_word = expected_smoothed.pop_front();
            if (seen_word.smoothed !== want_word.smoothed) begin
               report_mismatch("smoothed", 32'(seen_word.smoothed),
                               32'(want_word.smoothed));
            end
            if (seen_word.end_of_frame !== want_word.end_of_frame) begin
               report_mismatch("end_of_frame", 32'(seen_word.end_of_frame),
                               32'(want_word.end_of_frame));
            end
         end
         rsp_count <= rsp_count + 1;
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("weighted_window_max_filter regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      int total;
      int frame_len;
      build_tap_weights();
      for (int i = 0; i < WIN_LEN; i++) begin
         sample_line[i] = '0;
         line_valid[i]  = 1'b0;
      end

      // single-word frames at both extremes
      queue_word(16'hFFFF, 1'b1);
      queue_word(16'h0000, 1'b1);
      // short frame: all outputs come on the frame_end word
      queue_word(16'h0001, 1'b0);
      queue_word(16'hFFFF, 1'b0);
      queue_word(16'h0000, 1'b0);
      queue_word(16'h8000, 1'b1);
      // alternating bit patterns and near-full values
      queue_word(16'hAAAA, 1'b0);
      queue_word(16'h5555, 1'b0);
      queue_word(16'hFFFF, 1'b0);
      queue_word(16'hFFFF, 1'b0);
      queue_word(16'h0000, 1'b0);
      queue_word(16'h7FFF, 1'b0);
      queue_word(16'hFFFE, 1'b1);
      // lone peak: neighbors show the weight falloff on both sides
      for (int i = 0; i < 9; i++) begin
         queue_word((i == 4) ? 16'hFFFF : 16'h0000, i == 8);
      end

      // one long random frame first: fills the whole window and runs on past
      // its full length
      total = pending_words.size();
      for (int i = 0; i < 70; i++) begin
         queue_word(pick_sample(), i == 69);
      end
      total += 70;
      while (total < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            frame_len = $urandom_range(HALF_WINDOW + 1, 90);
         end else begin
            frame_len = $urandom_range(1, 40);
         end
         // last frame is cut to land on the run length
         if (frame_len > RANDOM_ITEMS - total) begin
            frame_len = RANDOM_ITEMS - total;
         end
         for (int i = 0; i < frame_len; i++) begin
            queue_word(pick_sample(), i == frame_len - 1);
         end
         total += frame_len;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // all words offered and accepted, then every result seen
      do begin
         @(posedge clock);
      end while (pending_words.size() != 0 || req_valid);
      do begin
         @(posedge clock);
      end while (expected_smoothed.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("weighted_window_max_filter regression: pass");
      end else begin
         $display("weighted_window_max_filter regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: weighted_window_max_filter.f
rtl/wwmf_pkg.sv
rtl/weighted_window_max_filter.sv
verif/weighted_window_max_filter_tb.sv
